### hw/rtl/tdrd_pkg.sv
// ----------------------------------------------------------------------------
// tdrd_pkg
// Shared constants, types and codes of the tile dirty region detector.
// ----------------------------------------------------------------------------
package tdrd_pkg;

    localparam int MAX_TILES = 32;
    localparam int TILE_W    = $clog2(MAX_TILES);
    localparam int CNT_W     = TILE_W + 1;
    localparam int PIX_W     = 32;
    localparam int COL_W     = 8;
    localparam int LINE_W    = 8;
    localparam int SIDE_W    = 9;
    localparam int FUZZ_W    = 8;
    localparam int SVAL_W    = 9;

    localparam logic [FUZZ_W-1:0] FUZZ_RESET = 8'd2;
    localparam logic [SVAL_W-1:0] NO_VALUE   = '1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_END   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TILE_W-1:0] tile_index;
        logic [COL_W-1:0]  column;
        logic [LINE_W-1:0] line;
        logic [SIDE_W-1:0] tile_width_now;
        logic [SIDE_W-1:0] run_height;
        logic [CNT_W-1:0]  tile_count;
        logic [PIX_W-1:0]  old_pixel;
        logic [PIX_W-1:0]  new_pixel;
    } item_t;

    typedef struct packed {
        logic [TILE_W-1:0] out_tile;
        logic              changed;
        logic [SVAL_W-1:0] first_changed_line;
        logic [SVAL_W-1:0] last_changed_line;
        logic              top_edge;
        logic              bottom_edge;
        logic              left_edge;
        logic              right_edge;
        logic [SVAL_W-1:0] first_column;
        logic [SVAL_W-1:0] last_column;
        logic              last_record;
    } rec_t;

    typedef struct packed {
        logic [LINE_W-1:0] lo_line;
        logic [LINE_W-1:0] hi_line;
        logic              left_flag;
        logic              right_flag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [MAX_TILES-1:0] tile_valid;
        logic                 col_valid;
        logic [COL_W-1:0]     col_min;
        logic [COL_W-1:0]     col_max;
    } view_t;

endpackage

### hw/rtl/tdrd_intf.sv
// ----------------------------------------------------------------------------
// tdrd_intf
// Channel interfaces: pixel/command items, tile records, register writes.
// ----------------------------------------------------------------------------
interface tdrd_item_if;
    logic           valid;
    logic           ready;
    tdrd_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tdrd_rec_if;
    logic           valid;
    logic           ready;
    tdrd_pkg::rec_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tdrd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tdrd_pkg::FUZZ_W-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/tdrd_ram.sv
// ----------------------------------------------------------------------------
// tdrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/tdrd_update.sv
// ----------------------------------------------------------------------------
// tdrd_update
// Read-modify-write of tile entries for pixel beats, with same-tile forwarding,
// per-tile valid bits and the run-wide column extent.
// ----------------------------------------------------------------------------
module tdrd_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_accept,
    input  tdrd_pkg::item_t               pix,
    input  logic [tdrd_pkg::FUZZ_W-1:0]   edge_fuzz,
    input  logic                          clear,
    input  tdrd_pkg::entry_t              rd_entry,
    output logic                          wr_en,
    output logic [tdrd_pkg::TILE_W-1:0]   wr_tile,
    output tdrd_pkg::entry_t              wr_entry,
    output tdrd_pkg::view_t               view
);

    logic                          s1_valid_reg;
    logic                          s1_diff_reg;
    logic [tdrd_pkg::TILE_W-1:0]   s1_tile_reg;
    logic [tdrd_pkg::COL_W-1:0]    s1_col_reg;
    logic [tdrd_pkg::LINE_W-1:0]   s1_line_reg;
    logic [tdrd_pkg::SIDE_W-1:0]   s1_width_reg;
    logic                          fwd_hit_reg;
    tdrd_pkg::entry_t              fwd_reg;
    logic [tdrd_pkg::MAX_TILES-1:0] tile_valid_reg;
    logic                          col_valid_reg;
    logic [tdrd_pkg::COL_W-1:0]    col_min_reg;
    logic [tdrd_pkg::COL_W-1:0]    col_max_reg;

    tdrd_pkg::entry_t              old_entry;
    tdrd_pkg::entry_t              new_entry;
    logic                          old_valid;
    logic [tdrd_pkg::SIDE_W-1:0]   fuzz_ext;
    logic [tdrd_pkg::SIDE_W-1:0]   col_ext;
    logic                          wide;
    logic                          in_left;
    logic                          in_right;

    always_comb
    begin
        old_entry = fwd_hit_reg ? fwd_reg : rd_entry;
        old_valid = tile_valid_reg[s1_tile_reg];
        fuzz_ext  = tdrd_pkg::SIDE_W'(edge_fuzz);
        col_ext   = tdrd_pkg::SIDE_W'(s1_col_reg);
        wide      = s1_width_reg > fuzz_ext;
        in_left   = wide && (col_ext < fuzz_ext);
        in_right  = wide && (col_ext >= s1_width_reg - fuzz_ext)
                         && (col_ext < s1_width_reg);
        if (old_valid)
        begin
            new_entry.lo_line    = (s1_line_reg < old_entry.lo_line)
                                   ? s1_line_reg : old_entry.lo_line;
            new_entry.hi_line    = (s1_line_reg > old_entry.hi_line)
                                   ? s1_line_reg : old_entry.hi_line;
            new_entry.left_flag  = old_entry.left_flag | in_left;
            new_entry.right_flag = old_entry.right_flag | in_right;
        end
        else
        begin
            new_entry.lo_line    = s1_line_reg;
            new_entry.hi_line    = s1_line_reg;
            new_entry.left_flag  = in_left;
            new_entry.right_flag = in_right;
        end
    end

    assign wr_en    = s1_valid_reg && s1_diff_reg;
    assign wr_tile  = s1_tile_reg;
    assign wr_entry = new_entry;

    assign view.tile_valid = tile_valid_reg;
    assign view.col_valid  = col_valid_reg;
    assign view.col_min    = col_min_reg;
    assign view.col_max    = col_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            tile_valid_reg <= '0;
            col_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pix_accept;
            fwd_hit_reg  <= pix_accept && wr_en && (pix.tile_index == s1_tile_reg);
            if (clear)
            begin
                tile_valid_reg <= '0;
                col_valid_reg  <= 1'b0;
            end
            else if (wr_en)
            begin
                tile_valid_reg[s1_tile_reg] <= 1'b1;
                col_valid_reg               <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_diff_reg  <= pix.old_pixel != pix.new_pixel;
            s1_tile_reg  <= pix.tile_index;
            s1_col_reg   <= pix.column;
            s1_line_reg  <= pix.line;
            s1_width_reg <= pix.tile_width_now;
        end
        fwd_reg <= new_entry;
        if (wr_en)
        begin
            if (!col_valid_reg || s1_col_reg < col_min_reg)
            begin
                col_min_reg <= s1_col_reg;
            end
            if (!col_valid_reg || s1_col_reg > col_max_reg)
            begin
                col_max_reg <= s1_col_reg;
            end
        end
    end

endmodule

### hw/rtl/tdrd_emit.sv
// ----------------------------------------------------------------------------
// tdrd_emit
// End-of-run sequencer: walks the tile entries, builds one record per tile
// into the output register, then clears the run state.
// ----------------------------------------------------------------------------
module tdrd_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          end_accept,
    input  tdrd_pkg::item_t               cmd_item,
    input  logic [tdrd_pkg::FUZZ_W-1:0]   edge_fuzz,
    input  tdrd_pkg::entry_t              rd_entry,
    input  tdrd_pkg::view_t               view,
    input  logic                          rec_ready,
    output logic                          rec_valid,
    output tdrd_pkg::rec_t                rec_data,
    output logic [tdrd_pkg::TILE_W-1:0]   rd_tile,
    output logic                          busy,
    output logic                          clear
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    state_t                        state_reg;
    logic [tdrd_pkg::TILE_W-1:0]   tile_reg;
    logic [tdrd_pkg::TILE_W-1:0]   last_tile_reg;
    logic                          single_reg;
    logic [tdrd_pkg::SIDE_W-1:0]   height_reg;
    logic                          rec_valid_reg;
    tdrd_pkg::rec_t                rec_reg;

    logic [tdrd_pkg::CNT_W-1:0]    count_sat;
    logic                          load;
    logic                          is_last;
    logic                          ch;
    logic [tdrd_pkg::SIDE_W:0]     bottom_sum;
    tdrd_pkg::rec_t                rec_next;

    always_comb
    begin
        if (cmd_item.tile_count == '0)
        begin
            count_sat = tdrd_pkg::CNT_W'(1);
        end
        else if (cmd_item.tile_count > tdrd_pkg::CNT_W'(tdrd_pkg::MAX_TILES))
        begin
            count_sat = tdrd_pkg::CNT_W'(tdrd_pkg::MAX_TILES);
        end
        else
        begin
            count_sat = cmd_item.tile_count;
        end
    end

    always_comb
    begin
        load       = (state_reg == S_LOAD) && (!rec_valid_reg || rec_ready);
        is_last    = tile_reg == last_tile_reg;
        ch         = view.tile_valid[tile_reg];
        bottom_sum = (tdrd_pkg::SIDE_W+1)'(rd_entry.hi_line)
                   + (tdrd_pkg::SIDE_W+1)'(edge_fuzz)
                   + (tdrd_pkg::SIDE_W+1)'(1);

        rec_next.out_tile           = tile_reg;
        rec_next.changed            = ch;
        rec_next.first_changed_line = ch ? {1'b0, rd_entry.lo_line} : tdrd_pkg::NO_VALUE;
        rec_next.last_changed_line  = ch ? {1'b0, rd_entry.hi_line} : tdrd_pkg::NO_VALUE;
        rec_next.top_edge           = ch && (rd_entry.lo_line < edge_fuzz);
        rec_next.bottom_edge        = ch && (bottom_sum > (tdrd_pkg::SIDE_W+1)'(height_reg));
        rec_next.left_edge          = ch && rd_entry.left_flag;
        rec_next.right_edge         = ch && rd_entry.right_flag;
        rec_next.first_column       = (single_reg && view.col_valid)
                                      ? {1'b0, view.col_min} : tdrd_pkg::NO_VALUE;
        rec_next.last_column        = (single_reg && view.col_valid)
                                      ? {1'b0, view.col_max} : tdrd_pkg::NO_VALUE;
        rec_next.last_record        = is_last;
    end

    assign rd_tile   = tile_reg;
    assign busy      = state_reg != S_IDLE;
    assign clear     = load && is_last;
    assign rec_valid = rec_valid_reg;
    assign rec_data  = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tile_reg      <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                rec_valid_reg <= 1'b1;
            end
            else if (rec_ready)
            begin
                rec_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (end_accept)
                    begin
                        tile_reg  <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (load)
                    begin
                        tile_reg  <= tile_reg + tdrd_pkg::TILE_W'(1);
                        state_reg <= is_last ? S_IDLE : S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_accept)
        begin
            last_tile_reg <= tdrd_pkg::TILE_W'(count_sat - tdrd_pkg::CNT_W'(1));
            single_reg    <= count_sat == tdrd_pkg::CNT_W'(1);
            height_reg    <= cmd_item.run_height;
        end
        if (load)
        begin
            rec_reg <= rec_next;
        end
    end

endmodule

### hw/rtl/tile_dirty_region_detector_unit.sv
// ----------------------------------------------------------------------------
// tile_dirty_region_detector_unit
// Tracks per-tile changed line span and edge-band hits over a run of tiles,
// and emits one record per tile on an end command.
//
//   channel | role   | beat
//   --------+--------+---------------------------------------------
//   item    | sink   | pixel pair (cmd 0) or end of run (cmd 1)
//   rec     | source | one tile record, last_record on final tile
//   cfg     | sink   | edge_fuzz write, always ready
//
// Pixel beats: one per cycle when not busy; a one-stage read-modify-write
// of the tile RAM with forwarding when consecutive beats hit the same tile.
// End beat: per record, a read state then a load state in the sequencer, item
// ready low until the last record is loaded; clear of valid bits is instant.
// Reset: asynchronous; clears valid bits, fuzz to 2; RAM is not swept.
// Record output is registered; a stalled rec holds the sequencer only.
// ----------------------------------------------------------------------------
module tile_dirty_region_detector_unit (
    input  logic               clk,
    input  logic               rst_n,
    tdrd_item_if.sink          item,
    tdrd_rec_if.source         rec,
    tdrd_cfg_if.sink           cfg
);

    logic [tdrd_pkg::FUZZ_W-1:0]   edge_fuzz_reg;
    logic                          item_accept;
    logic                          pix_accept;
    logic                          end_accept;
    logic                          busy;
    logic                          clear;
    logic                          wr_en;
    logic [tdrd_pkg::TILE_W-1:0]   wr_tile;
    tdrd_pkg::entry_t              wr_entry;
    tdrd_pkg::entry_t              rd_entry;
    logic [tdrd_pkg::TILE_W-1:0]   emit_tile;
    logic [tdrd_pkg::TILE_W-1:0]   rd_tile;
    tdrd_pkg::view_t               view;

    assign item.ready  = !busy;
    assign cfg.ready   = 1'b1;
    assign item_accept = item.valid && item.ready;
    assign pix_accept  = item_accept && (item.data.cmd == tdrd_pkg::CMD_PIXEL);
    assign end_accept  = item_accept && (item.data.cmd == tdrd_pkg::CMD_END);
    assign rd_tile     = busy ? emit_tile : item.data.tile_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_fuzz_reg <= tdrd_pkg::FUZZ_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            edge_fuzz_reg <= cfg.data;
        end
    end

    tdrd_ram #(
        .WIDTH (tdrd_pkg::ENTRY_W),
        .DEPTH (tdrd_pkg::MAX_TILES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_tile),
        .wdata (wr_entry),
        .raddr (rd_tile),
        .rdata (rd_entry)
    );

    tdrd_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_accept (pix_accept),
        .pix        (item.data),
        .edge_fuzz  (edge_fuzz_reg),
        .clear      (clear),
        .rd_entry   (rd_entry),
        .wr_en      (wr_en),
        .wr_tile    (wr_tile),
        .wr_entry   (wr_entry),
        .view       (view)
    );

    tdrd_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .end_accept (end_accept),
        .cmd_item   (item.data),
        .edge_fuzz  (edge_fuzz_reg),
        .rd_entry   (rd_entry),
        .view       (view),
        .rec_ready  (rec.ready),
        .rec_valid  (rec.valid),
        .rec_data   (rec.data),
        .rd_tile    (emit_tile),
        .busy       (busy),
        .clear      (clear)
    );

`ifndef SYNTHESIS
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (view.tile_valid == '0) && !view.col_valid)
        else $error("run state not cleared after last record");

    a_end_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        end_accept |=> busy)
        else $error("end beat did not start the record sequence");

    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(busy) && busy |-> !wr_en)
        else $error("tile RAM written during record sequence");

    a_last_record_ends: assert property (@(posedge clk) disable iff (!rst_n)
        clear |-> $past(busy) || busy)
        else $error("clear outside record sequence");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of tile_dirty_region_detector_unit. It streams runs of pixel
// pairs closed by end commands, plus random noise beats, and sweeps edge_fuzz
// between phases. A scoreboard class mirrors the per-tile line spans, band
// flags and column extent, and checks each tile record field by field.
// Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 52;

    class region_scoreboard;
        int             fuzz;
        int             line_lo    [tdrd_pkg::MAX_TILES];
        int             line_hi    [tdrd_pkg::MAX_TILES];
        bit             left_hit   [tdrd_pkg::MAX_TILES];
        bit             right_hit  [tdrd_pkg::MAX_TILES];
        int             min_col;
        int             max_col;
        tdrd_pkg::rec_t expected_recs[$];
        int             mismatches;

        function new();
            fuzz       = int'(tdrd_pkg::FUZZ_RESET);
            mismatches = 0;
            clear_run();
        endfunction

        function void clear_run();
            for (int t = 0; t < tdrd_pkg::MAX_TILES; t++)
            begin
                line_lo[t]   = -1;
                line_hi[t]   = -1;
                left_hit[t]  = 1'b0;
                right_hit[t] = 1'b0;
            end
            min_col = -1;
            max_col = -1;
        endfunction

        function void set_fuzz(logic [tdrd_pkg::FUZZ_W-1:0] value);
            fuzz = int'(value);
        endfunction

        function int pending();
            return expected_recs.size();
        endfunction

        function void note_item(tdrd_pkg::item_t it);
            int             t;
            int             col;
            int             ln;
            int             w;
            int             h;
            int             cnt;
            bit             hit;
            tdrd_pkg::rec_t r;
            t   = int'(it.tile_index);
            col = int'(it.column);
            ln  = int'(it.line);
            w   = int'(it.tile_width_now);
            h   = int'(it.run_height);
            cnt = int'(it.tile_count);
            if (it.cmd == tdrd_pkg::CMD_PIXEL)
            begin
                if (it.old_pixel == it.new_pixel)
                    return;
                if (line_lo[t] < 0 || ln < line_lo[t])
                    line_lo[t] = ln;
                if (line_hi[t] < 0 || ln > line_hi[t])
                    line_hi[t] = ln;
                if (w > fuzz)
                begin
                    if (col < fuzz)
                        left_hit[t] = 1'b1;
                    if (col >= w - fuzz && col < w)
                        right_hit[t] = 1'b1;
                end
                if (min_col < 0 || col < min_col)
                    min_col = col;
                if (max_col < 0 || col > max_col)
                    max_col = col;
                return;
            end
            if (cnt == 0)
                cnt = 1;
            if (cnt > tdrd_pkg::MAX_TILES)
                cnt = tdrd_pkg::MAX_TILES;
            for (int i = 0; i < cnt; i++)
            begin
                hit                  = (line_lo[i] >= 0);
                r.out_tile           = tdrd_pkg::TILE_W'(i);
                r.changed            = hit;
                r.first_changed_line = tdrd_pkg::SVAL_W'(line_lo[i]);
                r.last_changed_line  = tdrd_pkg::SVAL_W'(line_hi[i]);
                r.top_edge           = hit && (line_lo[i] < fuzz);
                r.bottom_edge        = hit && (line_hi[i] > (h - 1) - fuzz);
                r.left_edge          = left_hit[i];
                r.right_edge         = right_hit[i];
                r.first_column       = (cnt == 1) ? tdrd_pkg::SVAL_W'(min_col)
                                                  : tdrd_pkg::NO_VALUE;
                r.last_column        = (cnt == 1) ? tdrd_pkg::SVAL_W'(max_col)
                                                  : tdrd_pkg::NO_VALUE;
                r.last_record        = (i + 1 == cnt);
                expected_recs.push_back(r);
            end
            clear_run();
        endfunction

        function void report(string msg);
            if (mismatches < 10)
                $display("%s", msg);
            mismatches++;
        endfunction

        function void check_rec(tdrd_pkg::rec_t got);
            tdrd_pkg::rec_t exp;
            string          bad;
            if (expected_recs.size() == 0)
            begin
                report($sformatf("unexpected record: got %h", got));
                return;
            end
            exp = expected_recs.pop_front();
            bad = "";
            if (got.out_tile !== exp.out_tile)                     bad = {bad, " out_tile"};
            if (got.changed !== exp.changed)                       bad = {bad, " changed"};
            if (got.first_changed_line !== exp.first_changed_line) bad = {bad, " first_chg"};
            if (got.last_changed_line !== exp.last_changed_line)   bad = {bad, " last_chg"};
            if (got.top_edge !== exp.top_edge)                     bad = {bad, " top_edge"};
            if (got.bottom_edge !== exp.bottom_edge)               bad = {bad, " bottom_edge"};
            if (got.left_edge !== exp.left_edge)                   bad = {bad, " left_edge"};
            if (got.right_edge !== exp.right_edge)                 bad = {bad, " right_edge"};
            if (got.first_column !== exp.first_column)             bad = {bad, " first_column"};
            if (got.last_column !== exp.last_column)               bad = {bad, " last_column"};
            if (got.last_record !== exp.last_record)               bad = {bad, " last_record"};
            if (bad != "")
                report($sformatf("record mismatch (tile %0d):%s expected %h got %h",
                                 exp.out_tile, bad, exp, got));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    tdrd_item_if item_bus ();
    tdrd_rec_if  rec_bus ();
    tdrd_cfg_if  cfg_bus ();

    tile_dirty_region_detector_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_bus),
        .rec   (rec_bus),
        .cfg   (cfg_bus)
    );

    region_scoreboard sb;
    int items_sent;
    int burst_left;
    int stall_cycles;

    wire any_beat = (item_bus.valid && item_bus.ready) ||
                    (rec_bus.valid && rec_bus.ready) ||
                    (cfg_bus.valid && cfg_bus.ready);

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                sb.set_fuzz(cfg_bus.data);
            if (item_bus.valid && item_bus.ready)
                sb.note_item(item_bus.data);
            if (rec_bus.valid && rec_bus.ready)
                sb.check_rec(rec_bus.data);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || any_beat)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[tile_dirty_region_detector_unit] ERROR");
            $finish;
        end
    end

    // receiver: stall modes that switch at random
    initial
    begin
        int mode;
        int mode_left;
        int cyc;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        rec_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
                0:       rec_bus.ready <= 1'b1;
                1:       rec_bus.ready <= 1'($urandom_range(0, 1));
                2:       rec_bus.ready <= (cyc % 4 == 0);
                default: rec_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic tdrd_pkg::item_t mk_item(logic cmd, int tile, int col, int ln,
                                                int w, int h, int cnt,
                                                logic [tdrd_pkg::PIX_W-1:0] old_px,
                                                logic [tdrd_pkg::PIX_W-1:0] new_px);
        tdrd_pkg::item_t it;
        it.cmd            = cmd;
        it.tile_index     = tdrd_pkg::TILE_W'(tile);
        it.column         = tdrd_pkg::COL_W'(col);
        it.line           = tdrd_pkg::LINE_W'(ln);
        it.tile_width_now = tdrd_pkg::SIDE_W'(w);
        it.run_height     = tdrd_pkg::SIDE_W'(h);
        it.tile_count     = tdrd_pkg::CNT_W'(cnt);
        it.old_pixel      = old_px;
        it.new_pixel      = new_px;
        return it;
    endfunction

    function automatic logic [7:0] pick_coord(int n, int f);
        int v;
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = n - 1;
            2:       v = f - 1;
            3:       v = f;
            4:       v = n - f;
            5:       v = n - f - 1;
            default: v = $urandom_range(0, n - 1);
        endcase
        if (v > n - 1)
            v = n - 1;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    function automatic int pick_size(int f);
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(1, 8);
            1:       v = 256;
            2:       v = f + $urandom_range(0, 1);
            default: v = $urandom_range(1, 256);
        endcase
        if (v < 1)
            v = 1;
        if (v > 256)
            v = 256;
        return v;
    endfunction

    function automatic logic [tdrd_pkg::PIX_W-1:0] pick_new(logic [tdrd_pkg::PIX_W-1:0] old_px);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return old_px;
            4, 5, 6:    return old_px ^ (32'h1 << $urandom_range(0, 31));
            default:    return $urandom;
        endcase
    endfunction

    task automatic send_item(input tdrd_pkg::item_t it);
        if (burst_left == 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 5))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        item_bus.valid <= 1'b1;
        item_bus.data  <= it;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_fuzz(input logic [tdrd_pkg::FUZZ_W-1:0] value);
        drain();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_run();
        int cnt;
        int w;
        int lw;
        int h;
        int npix;
        int t;
        int tw;
        logic [tdrd_pkg::PIX_W-1:0] old_px;
        case ($urandom_range(0, 19))
            0:                   cnt = $urandom_range(6, 32);
            1, 2, 3, 4, 5, 6, 7: cnt = $urandom_range(2, 5);
            default:             cnt = 1;
        endcase
        w    = pick_size(sb.fuzz);
        lw   = $urandom_range(1, w);
        h    = pick_size(sb.fuzz);
        npix = $urandom_range(1, 24);
        repeat (npix)
        begin
            t      = $urandom_range(0, cnt - 1);
            tw     = (t == cnt - 1) ? lw : w;
            old_px = $urandom;
            send_item(mk_item(tdrd_pkg::CMD_PIXEL, t, int'(pick_coord(tw, sb.fuzz)),
                              int'(pick_coord(h, sb.fuzz)), tw, h, cnt, old_px,
                              pick_new(old_px)));
        end
        send_item(mk_item(tdrd_pkg::CMD_END, $urandom_range(0, 31), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 511), h, cnt,
                          $urandom, $urandom));
    endtask

    task automatic send_noise();
        logic [tdrd_pkg::PIX_W-1:0] old_px;
        repeat ($urandom_range(1, 5))
        begin
            old_px = $urandom;
            send_item(mk_item(($urandom_range(0, 9) == 0) ? tdrd_pkg::CMD_END : tdrd_pkg::CMD_PIXEL,
                              $urandom_range(0, 31), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 511),
                              $urandom_range(0, 511), $urandom_range(0, 63),
                              old_px, pick_new(old_px)));
        end
    endtask

    initial
    begin
        logic [tdrd_pkg::FUZZ_W-1:0] fuzz_plan [6];
        int phase_start;
        int roll;
        sb             = new();
        items_sent     = 0;
        burst_left     = 0;
        rst_n          <= 1'b0;
        item_bus.valid <= 1'b0;
        item_bus.data  <= '0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.data   <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats at the reset fuzz
        send_item(mk_item(tdrd_pkg::CMD_END, 0, 0, 0, 8, 8, 1, 32'h0, 32'h0));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 0, 0, 0, 8, 8, 1, 32'h0, 32'h1));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 0, 7, 7, 8, 8, 1, 32'ha5a5a5a5, 32'ha5a5a5a5));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 0, 7, 7, 8, 8, 1, 32'h0, 32'h80000000));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 0, 3, 2, 8, 8, 1, 32'h12345678, 32'h12345679));
        send_item(mk_item(tdrd_pkg::CMD_END, 0, 0, 0, 8, 8, 1, 32'h0, 32'h0));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 0, 0, 3, 2, 256, 32, 32'h0, 32'h100));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 1, 200, 5, 4, 256, 32, 32'h0, 32'h2));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 2, 255, 255, 256, 256, 32, 32'h0, 32'hffffffff));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 31, 128, 128, 256, 256, 32, 32'hffffffff, 32'h0));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 3, 254, 0, 256, 256, 32, 32'h55555555, 32'haaaaaaaa));
        send_item(mk_item(tdrd_pkg::CMD_END, 31, 255, 255, 511, 256, 32, 32'hffffffff, 32'hffffffff));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 0, 1, 1, 8, 1, 0, 32'h0, 32'h10000));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 1, 1, 1, 8, 1, 0, 32'h0, 32'h4));
        send_item(mk_item(tdrd_pkg::CMD_END, 0, 0, 0, 8, 1, 0, 32'h0, 32'h0));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 4, 5, 9, 6, 511, 63, 32'h7, 32'h3));
        send_item(mk_item(tdrd_pkg::CMD_END, 0, 0, 0, 6, 511, 63, 32'h0, 32'h0));
        send_item(mk_item(tdrd_pkg::CMD_PIXEL, 0, 0, 0, 1, 1, 1, 32'h0, 32'h8));
        send_item(mk_item(tdrd_pkg::CMD_END, 0, 0, 0, 1, 0, 33, 32'h0, 32'h0));

        fuzz_plan[0] = 8'd0;
        fuzz_plan[1] = 8'd255;
        fuzz_plan[2] = 8'd1;
        fuzz_plan[3] = tdrd_pkg::FUZZ_W'($urandom_range(3, 254));
        fuzz_plan[4] = 8'd128;
        fuzz_plan[5] = tdrd_pkg::FUZZ_RESET;
        for (int p = 0; p < 6; p++)
        begin
            write_fuzz(fuzz_plan[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    send_run();
                else if (roll < 92)
                    send_noise();
                else
                    drain();
            end
        end

        drain();
        repeat (20)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[tile_dirty_region_detector_unit] OK");
        else
            $display("[tile_dirty_region_detector_unit] ERROR");
        $finish;
    end

endmodule

### sim.f
hw/rtl/tdrd_pkg.sv
hw/rtl/tdrd_intf.sv
hw/rtl/tdrd_ram.sv
hw/rtl/tdrd_update.sv
hw/rtl/tdrd_emit.sv
hw/rtl/tile_dirty_region_detector_unit.sv
dv/tb_top.sv
